// ===== rtl/serial_programmed_sample_scheduler_assert.svh =====
// assertion macros for the scheduler rtl
`ifndef SERIAL_PROGRAMMED_SAMPLE_SCHEDULER_ASSERT_SVH
`define SERIAL_PROGRAMMED_SAMPLE_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sps_pkg.sv =====
// shared types, constants and character helpers of the sample scheduler
package sps_pkg;

  localparam int NUM_CHANNELS_DEF = 5;
  localparam int LINE_LEN_DEF     = 8;
  localparam int CHAN_W           = 3;
  localparam int BYTE_W           = 8;
  localparam int COUNT_W          = 16;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_LETTER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_NEWLINE = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// ===== rtl/sps_front.sv =====
// front end: accepts items, classifies them and queues them for the back end
module sps_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sps_pkg::in_item_t in_data,
  output logic           q_valid,
  output sps_pkg::cmd_t  q_cmd,
  input  logic           q_pop
);
  import sps_pkg::*;

  // two-entry queue
  cmd_t        entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        pop;
  cmd_t        cmd_in;

  always_comb begin
    cmd_in.data = in_data.rx_byte;
    if (in_data.opcode == OP_TICK) begin
      cmd_in.kind = KIND_TICK;
    end else if (in_data.rx_byte == CHAR_NEWLINE) begin
      cmd_in.kind = KIND_NEWLINE;
    end else begin
      cmd_in.kind = KIND_BYTE;
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/sps_back.sv =====
// back end: counters, line buffer, number parser and sample request output
module sps_back #(
  parameter int NUM_CHANNELS = sps_pkg::NUM_CHANNELS_DEF,
  parameter int LINE_LEN     = sps_pkg::LINE_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sps_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sps_pkg::out_item_t out_data
);
  import sps_pkg::*;

  localparam int FW  = $clog2(LINE_LEN + 1);
  localparam int IW  = $clog2(LINE_LEN);
  localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PARSE = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_W-1:0]     counts_r  [NUM_CHANNELS];
  logic [COUNT_W-1:0]     periods_r [NUM_CHANNELS];
  logic [BYTE_W-1:0]      buf_r     [LINE_LEN];
  logic [FW-1:0]          fill_r;
  logic [FW-1:0]          pos_r, pos_nxt;
  logic [COUNT_W-1:0]     acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic                   dig_r, dig_nxt;
  logic [CIW-1:0]         sel_r, sel_nxt;
  logic [NUM_CHANNELS-1:0] pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic [NUM_CHANNELS-1:0] due;
  logic [NUM_CHANNELS-1:0] pend_rest;
  logic [CHAN_W-1:0]      low_idx;
  logic [BYTE_W-1:0]      letter_off;
  logic                   is_letter;
  logic [BYTE_W-1:0]      cur_byte;
  logic [3:0]             digit_val;
  logic [COUNT_W-1:0]     acc_times_ten;

  // control strobes from the state logic
  logic do_tick, do_store, do_clear, do_write_period, do_check, out_load;

  assign q_pop = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      due[k] = (counts_r[k] >= periods_r[k]);
    end
  end

  // lowest pending channel
  always_comb begin
    low_idx = '0;
    for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        low_idx = CHAN_W'(k);
      end
    end
    pend_rest = pend_r & ~(NUM_CHANNELS'(1) << low_idx);
  end

  assign letter_off = buf_r[0] - CHAR_LETTER_A;
  assign is_letter  = (buf_r[0] >= CHAR_LETTER_A) &&
                      (letter_off < BYTE_W'(NUM_CHANNELS));
  assign cur_byte   = buf_r[pos_r[IW-1:0]];
  // ascii digits carry their value in the low nibble
  assign digit_val  = cur_byte[3:0];
  assign acc_times_ten = COUNT_W'({acc_r, 3'b000}) + COUNT_W'({acc_r, 1'b0});

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    acc_nxt         = acc_r;
    neg_nxt         = neg_r;
    dig_nxt         = dig_r;
    sel_nxt         = sel_r;
    pend_nxt        = pend_r;
    out_item_nxt    = out_item_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    do_tick         = 1'b0;
    do_store        = 1'b0;
    do_clear        = 1'b0;
    do_write_period = 1'b0;
    do_check        = 1'b0;
    out_load        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.kind == KIND_TICK) begin
            do_tick   = 1'b1;
            state_nxt = ST_CHECK;
          end else if (q_cmd.kind == KIND_BYTE && fill_r < FW'(LINE_LEN)) begin
            do_store  = 1'b1;
            state_nxt = ST_CHECK;
          end else if (is_letter) begin
            // line led by a channel letter: parse its number
            sel_nxt   = letter_off[CIW-1:0];
            pos_nxt   = FW'(1);
            acc_nxt   = '0;
            neg_nxt   = 1'b0;
            dig_nxt   = 1'b0;
            state_nxt = ST_PARSE;
          end else begin
            do_clear  = 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_PARSE: begin
        if (pos_r == FW'(LINE_LEN)) begin
          do_write_period = 1'b1;
          do_clear        = 1'b1;
          state_nxt       = ST_CHECK;
        end else if (!dig_r && is_blank(cur_byte)) begin
          pos_nxt = pos_r + FW'(1);
        end else if (!dig_r && (cur_byte == CHAR_PLUS || cur_byte == CHAR_MINUS)) begin
          neg_nxt = (cur_byte == CHAR_MINUS);
          dig_nxt = 1'b1;
          pos_nxt = pos_r + FW'(1);
        end else if (is_digit(cur_byte)) begin
          acc_nxt = acc_times_ten + COUNT_W'(digit_val);
          dig_nxt = 1'b1;
          pos_nxt = pos_r + FW'(1);
        end else begin
          do_write_period = 1'b1;
          do_clear        = 1'b1;
          state_nxt       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        do_check  = 1'b1;
        pend_nxt  = due;
        state_nxt = (due != '0) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load             = 1'b1;
          out_valid_nxt        = 1'b1;
          out_item_nxt.channel = low_idx;
          out_item_nxt.last    = (pend_rest == '0);
          pend_nxt             = pend_rest;
          if (pend_rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        counts_r[k]  <= '0;
        periods_r[k] <= COUNT_W'(1);
      end
      for (int i = 0; i < LINE_LEN; i++) begin
        buf_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_tick) begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          counts_r[k] <= counts_r[k] + COUNT_W'(1);
        end
      end else if (do_check) begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          if (due[k]) begin
            counts_r[k] <= '0;
          end
        end
      end
      if (do_store) begin
        buf_r[fill_r[IW-1:0]] <= q_cmd.data;
        fill_r                <= fill_r + FW'(1);
      end else if (do_clear) begin
        fill_r <= '0;
        for (int i = 0; i < LINE_LEN; i++) begin
          buf_r[i] <= '0;
        end
      end
      if (do_write_period) begin
        periods_r[sel_r] <= neg_r ? (COUNT_W'(0) - acc_r) : acc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    dig_r      <= dig_nxt;
    sel_r      <= sel_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`include "serial_programmed_sample_scheduler_assert.svh"

  `SPS_ASSERT_NOW(a_pend_only_emit, clk, rst_n, state_r != ST_EMIT, pend_r == '0, "pending requests outside emit")
  `SPS_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FW'(LINE_LEN), "line fill index overran the buffer")
  `SPS_ASSERT_NOW(a_load_has_pend, clk, rst_n, out_load, pend_r != '0, "output loaded with nothing pending")
  `SPS_ASSERT_NEXT(a_last_to_idle, clk, rst_n, out_load && out_item_nxt.last, state_r == ST_IDLE, "emit did not end on the final request")

endmodule

// ===== rtl/serial_programmed_sample_scheduler.sv =====
// top level of the serial-programmed sample scheduler
// usage:
//   in channel (in_valid/in_ready/in_data) takes one item per transfer: a
//   one-second tick (opcode 0) or a received serial byte (opcode 1)
//   out channel (out_valid/out_ready/out_data) gives one sample request per
//   transfer: the channel number and a last flag on the final request that
//   one item causes; an item with no channel due gives no transfer at all
// timing:
//   a two-entry queue sits between the front end and the back end, so items
//   are taken while the back end is busy or the receiver stalls
//   the back end runs one item at a time: it applies the item, compares the
//   counts with the periods, then sends out the sample requests in turn
//   a line led by a channel letter first goes through the number parser,
//   which walks the line buffer one byte per cycle
// reset: counts clear, periods go to one, line buffer and queue empty
// stall: a held request in the output register stops the back end; the
//   queue fills and then in_ready falls
module serial_programmed_sample_scheduler #(
  parameter int NUM_CHANNELS = sps_pkg::NUM_CHANNELS_DEF,
  parameter int LINE_LEN     = sps_pkg::LINE_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sps_pkg::out_item_t out_data
);
  import sps_pkg::*;

  // queue between front and back end
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // front end: classify ticks, plain bytes and newlines
  sps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // back end: state update, line parse and request sequencing
  sps_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .LINE_LEN     (LINE_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the serial-programmed sample scheduler
`timescale 1ns / 100ps

module tb_top;
  import sps_pkg::*;

  localparam int NCH          = NUM_CHANNELS_DEF;
  localparam int LLEN         = LINE_LEN_DEF;
  localparam int ITEM_TARGET  = 310;
  localparam int TAIL_CYCLES  = 2 + LLEN + NCH + 20;
  localparam int LIMIT_CYCLES = 400000;

  // blank characters not named in the package
  localparam logic [BYTE_W-1:0] CHAR_VT = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF = 8'h0C;

  // one row of the directed table; when has_due is set the due mask is the
  // expected answer, otherwise the predictor decides
  typedef struct packed {
    in_item_t          item;
    logic              has_due;
    logic [NCH-1:0]    due;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // side information that travels with the item on the input channel
  logic           cur_has_due;
  logic [NCH-1:0] cur_due;

  // predictor state
  logic [COUNT_W-1:0] elapsed [NCH];
  logic [COUNT_W-1:0] period [NCH];
  logic [BYTE_W-1:0]  line_buf [LLEN];
  int                 fill_idx;

  out_item_t pending_requests[$];
  dir_row_t  dir_rows[$];
  int        fail_count;
  int        items_sent;
  int        cycle_count;
  bit        no_idle;

  serial_programmed_sample_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic logic blank_char(input logic [BYTE_W-1:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // decimal value of the buffered line after its first byte, modulo 2^16
  function automatic logic [COUNT_W-1:0] line_value();
    int                 pos;
    logic               neg;
    logic [COUNT_W-1:0] acc;
    pos = 1;
    neg = 1'b0;
    acc = '0;
    while (pos < LLEN && blank_char(line_buf[pos])) pos++;
    if (pos < LLEN && (line_buf[pos] == CHAR_PLUS || line_buf[pos] == CHAR_MINUS)) begin
      neg = (line_buf[pos] == CHAR_MINUS);
      pos++;
    end
    while (pos < LLEN && line_buf[pos] >= CHAR_ZERO && line_buf[pos] <= CHAR_NINE) begin
      acc = acc * 16'd10 + {8'h00, line_buf[pos] - CHAR_ZERO};
      pos++;
    end
    if (neg) acc = -acc;
    return acc;
  endfunction

  // line finished: a leading channel letter reprograms that period, then
  // the buffer is wiped whatever it held
  function automatic void close_line();
    int k;
    if (line_buf[0] >= CHAR_LETTER_A && line_buf[0] < CHAR_LETTER_A + NCH)
      period[line_buf[0] - CHAR_LETTER_A] = line_value();
    fill_idx = 0;
    for (k = 0; k < LLEN; k++) line_buf[k] = '0;
  endfunction

  // apply one item and return the mask of channels due for a sample
  function automatic logic [NCH-1:0] advance_schedule(input in_item_t it);
    logic [NCH-1:0] due;
    int             k;
    due = '0;
    if (it.opcode == OP_TICK) begin
      for (k = 0; k < NCH; k++) elapsed[k] = elapsed[k] + 16'd1;
    end else if (it.rx_byte != CHAR_NEWLINE && fill_idx < LLEN) begin
      line_buf[fill_idx] = it.rx_byte;
      fill_idx++;
    end else begin
      close_line();
    end
    for (k = 0; k < NCH; k++) begin
      if (elapsed[k] >= period[k]) begin
        due[k]     = 1'b1;
        elapsed[k] = '0;
      end
    end
    return due;
  endfunction

  // ---------------------------------------------------------------------
  // monitor: predicts on each input transfer, checks each output transfer
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic [NCH-1:0] due;
    out_item_t      want;
    int             k;
    int             last_k;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        due = advance_schedule(in_data);
        // a typed-in row overrides the predictor's mask
        if (cur_has_due) due = cur_due;
        last_k = -1;
        for (k = 0; k < NCH; k++)
          if (due[k]) last_k = k;
        for (k = 0; k < NCH; k++) begin
          if (due[k]) begin
            want.channel = k[CHAN_W-1:0];
            want.last    = (k == last_k);
            pending_requests.push_back(want);
          end
        end
      end
      if (out_valid && out_ready) begin
        if (pending_requests.size() == 0) begin
          $error("unexpected sample request: channel %0d last %0d",
                 out_data.channel, out_data.last);
          fail_count++;
        end else begin
          want = pending_requests.pop_front();
          if (out_data.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, out_data.channel);
            fail_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // driving helpers
  // ---------------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one item and hold it until the transfer; returns on the
  // rising edge at which it was taken, with valid still high
  task automatic send_item(input in_item_t it, input logic has_due,
                           input logic [NCH-1:0] due);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= it;
    cur_has_due <= has_due;
    cur_due     <= due;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop sending and let every outstanding request come out
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_requests.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // one serial line, led by a letter that may fall just outside the channels;
  // well-formed lines add a number, broken ones carry random bytes and may be left open
  task automatic send_line(input bit well_formed);
    logic [BYTE_W-1:0] line[$];
    logic [BYTE_W-1:0] digs[$];
    logic [BYTE_W-1:0] letter;
    int                v;
    int                r;
    r = $urandom_range(0, 9);
    if (r == 0)
      letter = $urandom_range(0, 1) ? CHAR_LETTER_A - 8'd1 : CHAR_LETTER_A + 8'(NCH);
    else
      letter = CHAR_LETTER_A + 8'($urandom_range(0, NCH - 1));
    line.push_back(letter);
    if (well_formed) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 4))
            0:       line.push_back(CHAR_SPACE);
            1:       line.push_back(CHAR_TAB);
            2:       line.push_back(CHAR_VT);
            3:       line.push_back(CHAR_FF);
            default: line.push_back(CHAR_CR);
          endcase
        end
      end
      r = $urandom_range(0, 9);
      if (r == 0) line.push_back(CHAR_MINUS);
      else if (r == 1) line.push_back(CHAR_PLUS);
      // mostly short periods so that requests keep coming
      r = $urandom_range(0, 99);
      if (r < 70) v = $urandom_range(0, 15);
      else if (r < 85) v = $urandom_range(16, 300);
      else if (r < 95) v = $urandom_range(0, 65535);
      else v = $urandom_range(65536, 9999999);
      do begin
        digs.push_front(CHAR_ZERO + 8'(v % 10));
        v = v / 10;
      end while (v != 0);
      foreach (digs[k]) line.push_back(digs[k]);
    end else begin
      repeat ($urandom_range(0, 9)) line.push_back(8'($urandom_range(0, 255)));
    end
    if (well_formed || $urandom_range(0, 1)) line.push_back(CHAR_NEWLINE);
    foreach (line[k]) begin
      // ticks sometimes land in the middle of a line
      if ($urandom_range(0, 7) == 0)
        send_item({OP_TICK, 8'($urandom_range(0, 255))}, 1'b0, '0);
      send_item({OP_BYTE, line[k]}, 1'b0, '0);
    end
  endtask

  task automatic add_row(input logic op, input logic [BYTE_W-1:0] b,
                         input logic has_due, input logic [NCH-1:0] due);
    dir_rows.push_back({op, b, has_due, due});
  endtask

  // ---------------------------------------------------------------------
  // receiver: ready with random stalls, and long stretches without any
  // ---------------------------------------------------------------------
  initial begin : receiver
    int run;
    int stall;
    out_ready = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 12);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** serial_programmed_sample_scheduler: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int       k;
    int       r;
    bit       drained;
    dir_row_t row;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cur_has_due = 1'b0;
    cur_due     = '0;
    fail_count  = 0;
    items_sent  = 0;
    no_idle     = 1'b0;
    drained     = 1'b0;
    for (k = 0; k < NCH; k++) begin
      elapsed[k] = '0;
      period[k]  = 16'd1;
    end
    for (k = 0; k < LLEN; k++) line_buf[k] = '0;
    fill_idx = 0;

    // first tick after reset: every period is one, so all channels fire
    add_row(OP_TICK, CHAR_NEWLINE, 1'b1, 5'b11111);
    // "A0" then newline: period of A becomes zero and A fires at once
    add_row(OP_BYTE, "A",          1'b1, 5'b00000);
    add_row(OP_BYTE, "0",          1'b1, 5'b00000);
    add_row(OP_BYTE, CHAR_NEWLINE, 1'b1, 5'b00001);
    // "B -1": blank, sign, negation wraps to the largest period
    add_row(OP_BYTE, "B",          1'b0, '0);
    add_row(OP_BYTE, CHAR_SPACE,   1'b0, '0);
    add_row(OP_BYTE, CHAR_MINUS,   1'b0, '0);
    add_row(OP_BYTE, "1",          1'b0, '0);
    add_row(OP_BYTE, CHAR_NEWLINE, 1'b0, '0);
    // "C+65535X" fills the buffer; the next byte ends the line unstored
    add_row(OP_BYTE, "C",          1'b1, 5'b00001);
    add_row(OP_BYTE, CHAR_PLUS,    1'b1, 5'b00001);
    add_row(OP_BYTE, "6",          1'b1, 5'b00001);
    add_row(OP_BYTE, "5",          1'b1, 5'b00001);
    add_row(OP_BYTE, "5",          1'b1, 5'b00001);
    add_row(OP_BYTE, "3",          1'b1, 5'b00001);
    add_row(OP_BYTE, "5",          1'b1, 5'b00001);
    add_row(OP_BYTE, "X",          1'b1, 5'b00001);
    add_row(OP_BYTE, 8'hFF,        1'b1, 5'b00001);
    // empty line: no period changes
    add_row(OP_BYTE, CHAR_NEWLINE, 1'b1, 5'b00001);
    // "A3" takes A off its every-item schedule
    add_row(OP_BYTE, "A",          1'b1, 5'b00001);
    add_row(OP_BYTE, "3",          1'b1, 5'b00001);
    add_row(OP_BYTE, CHAR_NEWLINE, 1'b1, 5'b00000);
    // tick with a stray byte on the bus: only D and E are still at one
    add_row(OP_TICK, 8'hFF,        1'b1, 5'b11000);
    // a line led by a zero byte is not a channel line; nothing due
    add_row(OP_BYTE, 8'h00,        1'b1, 5'b00000);
    add_row(OP_BYTE, CHAR_NEWLINE, 1'b1, 5'b00000);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      send_item(row.item, row.has_due, row.due);
    end

    while (items_sent < ITEM_TARGET) begin
      // once, half way, the sender holds back until everything is out
      if (!drained && items_sent >= ITEM_TARGET / 2) begin
        drain_requests();
        drained = 1'b1;
      end
      // a stretch of back-to-back transfers in every hundred items
      no_idle = (items_sent % 100) >= 70;
      r = $urandom_range(0, 99);
      if (r < 35)
        send_item({OP_TICK, 8'($urandom_range(0, 255))}, 1'b0, '0);
      else if (r < 75)
        send_line(1'b1);
      else if (r < 90)
        send_line(1'b0);
      else
        send_item({OP_BYTE, 8'($urandom_range(0, 255))}, 1'b0, '0);
    end

    drain_requests();
    if (fail_count == 0 && pending_requests.size() == 0)
      $display("** serial_programmed_sample_scheduler: PASSED **");
    else
      $display("** serial_programmed_sample_scheduler: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_front.sv
rtl/sps_back.sv
rtl/serial_programmed_sample_scheduler.sv
tb/tb_top.sv
